### rtl/ctd_pkg.sv
`timescale 1ns / 1ps

package ctd_pkg;

  localparam int unsigned COLOR_W = 16;
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned TEXEL_W = 4;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SEL_W   = 2;

  // Multiplying by 171 and shifting right by nine divides any 8-bit value by three exactly.
  localparam logic [7:0] DIV3_MUL   = 8'd171;
  localparam int unsigned DIV3_SHIFT = 9;

  typedef enum logic [SEL_W-1:0] {
    SEL_A   = 2'd0,
    SEL_B   = 2'd1,
    SEL_MIX = 2'd2,
    SEL_LOW = 2'd3
  } sel_e;

endpackage

### rtl/ctd_decode.sv
`timescale 1ns / 1ps

module ctd_decode (
  input  logic [ctd_pkg::COLOR_W-1:0] color_a_i,
  input  logic [ctd_pkg::COLOR_W-1:0] color_b_i,
  input  logic [ctd_pkg::INDEX_W-1:0] index_bits_i,
  input  logic [ctd_pkg::TEXEL_W-1:0] texel_i,
  output logic [ctd_pkg::CHAN_W-1:0]  red_o,
  output logic [ctd_pkg::CHAN_W-1:0]  green_o,
  output logic [ctd_pkg::CHAN_W-1:0]  blue_o
);

  function automatic logic [5:0] mix_ch(logic [5:0] a, logic [5:0] b, logic four,
                                        logic heavy_a);
    logic [7:0]  sum;
    logic [15:0] prod;
    logic [5:0]  res;
    if (four) begin
      if (heavy_a) begin
        sum = {1'b0, a, 1'b0} + {2'b00, b};
      end else begin
        sum = {2'b00, a} + {1'b0, b, 1'b0};
      end
      prod = sum * ctd_pkg::DIV3_MUL;
      res  = prod[ctd_pkg::DIV3_SHIFT +: 6];
    end else begin
      sum = {2'b00, a} + {2'b00, b};
      res = sum[6:1];
    end
    return res;
  endfunction

  logic                      four_color;
  logic [ctd_pkg::SEL_W-1:0] sel_raw;
  ctd_pkg::sel_e             sel;
  logic [4:0]                ra, rb, ba, bb;
  logic [5:0]                ga, gb;
  logic [5:0]                r2, g2, b2, r3, g3, b3;
  logic [4:0]                r_sel, b_sel;
  logic [5:0]                g_sel;

  assign four_color = color_a_i > color_b_i;

  assign ra = color_a_i[15:11];
  assign ga = color_a_i[10:5];
  assign ba = color_a_i[4:0];
  assign rb = color_b_i[15:11];
  assign gb = color_b_i[10:5];
  assign bb = color_b_i[4:0];

  assign r2 = mix_ch({1'b0, ra}, {1'b0, rb}, four_color, 1'b1);
  assign g2 = mix_ch(ga, gb, four_color, 1'b1);
  assign b2 = mix_ch({1'b0, ba}, {1'b0, bb}, four_color, 1'b1);
  assign r3 = four_color ? mix_ch({1'b0, ra}, {1'b0, rb}, 1'b1, 1'b0) : 6'd0;
  assign g3 = four_color ? mix_ch(ga, gb, 1'b1, 1'b0) : 6'd0;
  assign b3 = four_color ? mix_ch({1'b0, ba}, {1'b0, bb}, 1'b1, 1'b0) : 6'd0;

  // Texel 0 sits in the top two bits, so the upper bit of a texel's pair is at 31 - 2 * texel.
  assign sel_raw = index_bits_i[{~texel_i, 1'b1} -: ctd_pkg::SEL_W];
  assign sel     = ctd_pkg::sel_e'(sel_raw);

  always_comb begin
    unique case (sel)
      ctd_pkg::SEL_A: begin
        r_sel = ra;
        g_sel = ga;
        b_sel = ba;
      end
      ctd_pkg::SEL_B: begin
        r_sel = rb;
        g_sel = gb;
        b_sel = bb;
      end
      ctd_pkg::SEL_MIX: begin
        r_sel = r2[4:0];
        g_sel = g2;
        b_sel = b2[4:0];
      end
      default: begin
        r_sel = r3[4:0];
        g_sel = g3;
        b_sel = b3[4:0];
      end
    endcase
  end

  assign red_o   = {r_sel, 3'b000};
  assign green_o = {g_sel[5:1], 3'b000};
  assign blue_o  = {b_sel, 3'b000};

endmodule

### rtl/compressed_texel_decode.sv
`timescale 1ns / 1ps

// Decodes one texel of a 4x4 block-compressed color block per item and accepts a new item
// every clock cycle while the output side does not hold it back. Each item is captured in an
// input register, the palette is built and the texel's entry selected in combinational logic,
// and the color, 8 bits per channel, lands in a result register that presents it. While a
// finished result waits, the input stays ready only as long as the input register is empty;
// once both registers hold an item, the input is held until the result is taken.
module compressed_texel_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ctd_pkg::COLOR_W-1:0] color_a_i,
  input  logic [ctd_pkg::COLOR_W-1:0] color_b_i,
  input  logic [ctd_pkg::INDEX_W-1:0] index_bits_i,
  input  logic [ctd_pkg::TEXEL_W-1:0] texel_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ctd_pkg::CHAN_W-1:0]  red_o,
  output logic [ctd_pkg::CHAN_W-1:0]  green_o,
  output logic [ctd_pkg::CHAN_W-1:0]  blue_o
);

  logic                        in_valid_q;
  logic [ctd_pkg::COLOR_W-1:0] color_a_q, color_b_q;
  logic [ctd_pkg::INDEX_W-1:0] index_bits_q;
  logic [ctd_pkg::TEXEL_W-1:0] texel_q;
  logic                        out_valid_q;
  logic [ctd_pkg::CHAN_W-1:0]  red_q, green_q, blue_q;
  logic [ctd_pkg::CHAN_W-1:0]  red_d, green_d, blue_d;
  logic                        out_adv;
  logic                        in_take;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_adv;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      color_a_q    <= color_a_i;
      color_b_q    <= color_b_i;
      index_bits_q <= index_bits_i;
      texel_q      <= texel_i;
    end
    if (out_adv && in_valid_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  ctd_decode u_decode (
    .color_a_i    (color_a_q),
    .color_b_i    (color_b_q),
    .index_bits_i (index_bits_q),
    .texel_i      (texel_q),
    .red_o        (red_d),
    .green_o      (green_d),
    .blue_o       (blue_d)
  );

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } texel_rgb_t;

  typedef struct packed {
    logic [15:0] color_a;
    logic [15:0] color_b;
    logic [31:0] index_bits;
    logic [3:0]  texel;
    logic        known;
    texel_rgb_t  rgb;
  } texel_case_t;

  localparam int unsigned NUM_DIRECTED = 24;
  localparam int unsigned NUM_RANDOM   = 650;

  // Rows with known set carry an expected color read straight off an endpoint, or black for selector 3 when A <= B.
  localparam texel_case_t DIRECTED_CASES [NUM_DIRECTED] = '{
    '{16'h0000, 16'h0000, 32'h0000_0000, 4'd0,  1'b1, '{8'h00, 8'h00, 8'h00}},
    '{16'hffff, 16'h0000, 32'h0000_0000, 4'd0,  1'b1, '{8'hf8, 8'hf8, 8'hf8}},
    '{16'hffff, 16'h0000, 32'h4000_0000, 4'd0,  1'b1, '{8'h00, 8'h00, 8'h00}},
    '{16'hffff, 16'h0000, 32'h8000_0000, 4'd0,  1'b0, '{8'h00, 8'h00, 8'h00}},
    '{16'hffff, 16'h0000, 32'hc000_0000, 4'd0,  1'b0, '{8'h00, 8'h00, 8'h00}},
    '{16'h0000, 16'hffff, 32'h0000_0000, 4'd0,  1'b1, '{8'h00, 8'h00, 8'h00}},
    '{16'h0000, 16'hffff, 32'h4000_0000, 4'd0,  1'b1, '{8'hf8, 8'hf8, 8'hf8}},
    '{16'h0000, 16'hffff, 32'h8000_0000, 4'd0,  1'b0, '{8'h00, 8'h00, 8'h00}},
    '{16'h0000, 16'hffff, 32'hc000_0000, 4'd0,  1'b1, '{8'h00, 8'h00, 8'h00}},
    '{16'hffff, 16'hffff, 32'hffff_ffff, 4'd15, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{16'hffff, 16'hffff, 32'haaaa_aaaa, 4'd15, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{16'hffff, 16'hffff, 32'h0000_0000, 4'd7,  1'b1, '{8'hf8, 8'hf8, 8'hf8}},
    '{16'h8001, 16'h8000, 32'hffff_ffff, 4'd3,  1'b0, '{8'h00, 8'h00, 8'h00}},
    '{16'h8000, 16'h8001, 32'hffff_ffff, 4'd3,  1'b1, '{8'h00, 8'h00, 8'h00}},
    '{16'hf800, 16'h07e0, 32'he4e4_e4e4, 4'd0,  1'b0, '{8'h00, 8'h00, 8'h00}},
    '{16'hf800, 16'h07e0, 32'he4e4_e4e4, 4'd1,  1'b0, '{8'h00, 8'h00, 8'h00}},
    '{16'hf800, 16'h07e0, 32'he4e4_e4e4, 4'd2,  1'b1, '{8'h00, 8'hf8, 8'h00}},
    '{16'hf800, 16'h07e0, 32'he4e4_e4e4, 4'd3,  1'b1, '{8'hf8, 8'h00, 8'h00}},
    '{16'h001f, 16'hf800, 32'h1b1b_1b1b, 4'd12, 1'b1, '{8'h00, 8'h00, 8'hf8}},
    '{16'h001f, 16'hf800, 32'h1b1b_1b1b, 4'd15, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{16'h07e0, 16'h0020, 32'h5555_5555, 4'd9,  1'b1, '{8'h00, 8'h00, 8'h00}},
    '{16'h7bef, 16'h7bef, 32'h1234_5678, 4'd6,  1'b0, '{8'h00, 8'h00, 8'h00}},
    '{16'hffff, 16'hfffe, 32'hffff_ffff, 4'd0,  1'b0, '{8'h00, 8'h00, 8'h00}},
    '{16'h0001, 16'h0000, 32'haaaa_aaaa, 4'd5,  1'b0, '{8'h00, 8'h00, 8'h00}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] color_a = '0;
  logic [15:0] color_b = '0;
  logic [31:0] index_bits = '0;
  logic [3:0]  texel = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  logic        use_known = 1'b0;
  texel_rgb_t  known_rgb = '0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;

  texel_rgb_t  texel_exp_q[$];
  int unsigned error_count = 0;

  compressed_texel_decode dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .color_a_i    (color_a),
    .color_b_i    (color_b),
    .index_bits_i (index_bits),
    .texel_i      (texel),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [15:0] blend565(input int unsigned wa, input int unsigned wb,
                                           input logic [15:0] ca, input logic [15:0] cb);
    int unsigned den;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    den = wa + wb;
    r = (wa * ca[15:11] + wb * cb[15:11]) / den;
    g = (wa * ca[10:5] + wb * cb[10:5]) / den;
    b = (wa * ca[4:0] + wb * cb[4:0]) / den;
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  function automatic texel_rgb_t decode_texel(input logic [15:0] ca, input logic [15:0] cb,
                                              input logic [31:0] bits, input logic [3:0] pos);
    ctd_pkg::sel_e sel;
    logic [15:0]   raw;
    texel_rgb_t    rgb;
    sel = ctd_pkg::sel_e'(bits[31 - 2 * int'(pos) -: 2]);
    case (sel)
      ctd_pkg::SEL_A:   raw = ca;
      ctd_pkg::SEL_B:   raw = cb;
      ctd_pkg::SEL_MIX: raw = (ca > cb) ? blend565(2, 1, ca, cb) : blend565(1, 1, ca, cb);
      ctd_pkg::SEL_LOW: raw = (ca > cb) ? blend565(1, 2, ca, cb) : 16'h0000;
      default:          raw = 16'h0000;
    endcase
    rgb.red   = {raw[15:11], 3'b000};
    rgb.green = {raw[10:6], 3'b000};
    rgb.blue  = {raw[4:0], 3'b000};
    return rgb;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk_i) begin : scoreboard
    texel_rgb_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        texel_exp_q.push_back(use_known ? known_rgb
                                        : decode_texel(color_a, color_b, index_bits, texel));
      end
      if (out_valid && out_ready) begin
        if (texel_exp_q.size() == 0) begin
          $error("unexpected result: red %0h green %0h blue %0h", red, green, blue);
          error_count++;
        end else begin
          want = texel_exp_q.pop_front();
          if (red !== want.red) begin
            $error("red mismatch: expected %0h, actual %0h", want.red, red);
            error_count++;
          end
          if (green !== want.green) begin
            $error("green mismatch: expected %0h, actual %0h", want.green, green);
            error_count++;
          end
          if (blue !== want.blue) begin
            $error("blue mismatch: expected %0h, actual %0h", want.blue, blue);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(negedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic drive_item(input logic [15:0] ca, input logic [15:0] cb,
                            input logic [31:0] bits, input logic [3:0] pos);
    in_valid   <= 1'b1;
    color_a    <= ca;
    color_b    <= cb;
    index_bits <= bits;
    texel      <= pos;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    if (!tx_quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (texel_exp_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] ca;
    logic [15:0] cb;
    int unsigned kind;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_CASES[i]) begin
      use_known <= DIRECTED_CASES[i].known;
      known_rgb <= DIRECTED_CASES[i].rgb;
      drive_item(DIRECTED_CASES[i].color_a, DIRECTED_CASES[i].color_b,
                 DIRECTED_CASES[i].index_bits, DIRECTED_CASES[i].texel);
    end
    use_known <= 1'b0;
    drain_results();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 100 == 0) begin
        tx_quiet = ((i / 100) % 3 == 1);
        rx_quiet = ((i / 100) % 3 != 0);
      end
      if (i % 200 == 150) begin
        drain_results();
      end
      ca   = 16'($urandom());
      cb   = 16'($urandom());
      kind = $urandom_range(0, 9);
      case (kind)
        6: cb = ca;
        7: if (ca <= cb) {ca, cb} = {cb, ca};
        8: cb = $urandom_range(0, 1) ? ca + 16'd1 : ca - 16'd1;
        9: begin
          ca = {{5{$urandom_range(0, 1) == 1}}, {6{$urandom_range(0, 1) == 1}},
                {5{$urandom_range(0, 1) == 1}}};
          cb = {{5{$urandom_range(0, 1) == 1}}, {6{$urandom_range(0, 1) == 1}},
                {5{$urandom_range(0, 1) == 1}}};
        end
        default: ;
      endcase
      drive_item(ca, cb, $urandom(), 4'($urandom_range(0, 15)));
    end

    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    in_valid <= 1'b0;
    while (texel_exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && texel_exp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(64'd5_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
